### rtl/crast_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the circle rasterizer.
// No dependencies; used by crast_front, crast_back, the top level and the testbench.

package crast_pkg;

   // Defaults for top-level parameters
   localparam int COORD_BITS_DEF  = 11;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Decision variable width (wraps two's complement)
   localparam int DEC_BITS = 16;
   typedef logic signed [DEC_BITS-1:0] dec_type;

   // Midpoint constants
   localparam dec_type DEC_INIT = dec_type'(3);
   localparam dec_type INC_NEG  = dec_type'(6);
   localparam dec_type INC_POS  = dec_type'(10);
   localparam int      DEC_SHIFT = 2;   // multiply by 4

   // Request codes
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   // Eight symmetric points per step
   localparam int PHASE_BITS = 3;
   typedef logic [PHASE_BITS-1:0] phase_type;
   localparam phase_type PHASE_FIRST = phase_type'(0);
   localparam phase_type PHASE_LAST  = phase_type'(7);

endpackage

### rtl/crast_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, holds circle state, runs the midpoint update.
// Depends on crast_pkg; feeds commands into crast_queue.

module crast_front #(
   parameter int COORD_BITS = crast_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic        [COORD_BITS-2:0] req_radius,
   input  logic                        queue_full,
   output logic                        cmd_push,
   output logic [4*COORD_BITS:0]       cmd_data
);

   localparam int CB = COORD_BITS;

   logic signed [CB-1:0] center_x_ff, center_x_in;
   logic signed [CB-1:0] center_y_ff, center_y_in;
   logic signed [CB-1:0] offset_x_ff, offset_x_in;
   logic signed [CB-1:0] offset_y_ff, offset_y_in;
   crast_pkg::dec_type   decision_ff, decision_in;
   logic                 active_ff, active_in;

   logic                 accept;
   logic                 is_start;
   logic                 is_done;
   logic signed [CB-1:0] base_cx, base_cy, base_x, base_y;
   crast_pkg::dec_type   base_d;
   crast_pkg::dec_type   x_ext, y_ext;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign is_start  = (req_type == crast_pkg::REQ_START);
   assign is_done   = !is_start && (!active_ff || (offset_x_ff > offset_y_ff));

   // Values for this step: fresh circle on start, held state otherwise
   always_comb begin
      if (is_start) begin
         base_cx = req_center_x;
         base_cy = req_center_y;
         base_x  = '0;
         base_y  = CB'(req_radius);
         base_d  = crast_pkg::DEC_INIT
                 - (crast_pkg::dec_type'(req_radius) <<< 1);
      end else begin
         base_cx = center_x_ff;
         base_cy = center_y_ff;
         base_x  = offset_x_ff;
         base_y  = offset_y_ff;
         base_d  = decision_ff;
      end
   end

   assign x_ext = crast_pkg::dec_type'(base_x);
   assign y_ext = crast_pkg::dec_type'(base_y);

   // Next state: midpoint advance on emitting steps, deactivate on done
   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      decision_in = decision_ff;
      active_in   = active_ff;
      if (accept) begin
         if (is_done) begin
            active_in = 1'b0;
         end else begin
            center_x_in = base_cx;
            center_y_in = base_cy;
            active_in   = 1'b1;
            offset_x_in = base_x + CB'(1);
            if (base_d[crast_pkg::DEC_BITS-1]) begin
               decision_in = base_d + (x_ext <<< crast_pkg::DEC_SHIFT)
                           + crast_pkg::INC_NEG;
               offset_y_in = base_y;
            end else begin
               decision_in = base_d + ((x_ext - y_ext) <<< crast_pkg::DEC_SHIFT)
                           + crast_pkg::INC_POS;
               offset_y_in = base_y - CB'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         decision_ff <= '0;
         active_ff   <= 1'b0;
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
         decision_ff <= decision_in;
         active_ff   <= active_in;
      end
   end

   // Command carries the pre-advance offsets for the eight points
   assign cmd_push = accept;
   assign cmd_data = {is_done, base_cx, base_cy, base_x, base_y};

endmodule

### rtl/crast_queue.sv
`timescale 1ns / 1ps
// Small register FIFO between front end and point sequencer.
// Depends on nothing but its parameters.

module crast_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == CNT_BITS'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/crast_back.sv
`timescale 1ns / 1ps
// Point sequencer: walks the eight symmetric points of the queue head.
// Depends on crast_pkg; drains crast_queue into the result register.

module crast_back #(
   parameter int COORD_BITS = crast_pkg::COORD_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  logic [4*COORD_BITS:0]      head_data,
   output logic                       head_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [COORD_BITS:0] rsp_point_x,
   output logic signed [COORD_BITS:0] rsp_point_y,
   output logic                       rsp_last,
   output logic                       rsp_done_res
);

   localparam int CB = COORD_BITS;
   localparam int PW = COORD_BITS + 1;

   logic                 hd_done;
   logic signed [CB-1:0] hd_cx, hd_cy, hd_x, hd_y;
   logic signed [CB-1:0] sel_a, sel_b;
   logic signed [PW-1:0] pt_x, pt_y;
   logic                 pt_last;
   logic                 out_ready;

   crast_pkg::phase_type phase_ff, phase_in;
   logic                 valid_ff, valid_in;
   logic signed [PW-1:0] point_x_ff, point_y_ff;
   logic                 last_ff, done_ff;

   assign {hd_done, hd_cx, hd_cy, hd_x, hd_y} = head_data;

   // Phase bit 2 swaps x/y, bit 1 negates the y term, bit 0 the x term
   always_comb begin
      sel_a = phase_ff[2] ? hd_y : hd_x;
      sel_b = phase_ff[2] ? hd_x : hd_y;
      pt_x  = phase_ff[0] ? PW'(hd_cx) - PW'(sel_a) : PW'(hd_cx) + PW'(sel_a);
      pt_y  = phase_ff[1] ? PW'(hd_cy) - PW'(sel_b) : PW'(hd_cy) + PW'(sel_b);
   end

   assign pt_last   = hd_done || (phase_ff == crast_pkg::PHASE_LAST);
   assign out_ready = !valid_ff || !rsp_stall;
   assign head_pop  = out_ready && head_valid && pt_last;

   // Phase counter and result-register valid
   always_comb begin
      phase_in = phase_ff;
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = head_valid;
         if (head_valid) begin
            phase_in = pt_last ? crast_pkg::PHASE_FIRST : phase_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= crast_pkg::PHASE_FIRST;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (out_ready && head_valid) begin
         point_x_ff <= hd_done ? '0 : pt_x;
         point_y_ff <= hd_done ? '0 : pt_y;
         last_ff    <= pt_last;
         done_ff    <= hd_done;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_point_x  = point_x_ff;
   assign rsp_point_y  = point_y_ff;
   assign rsp_last     = last_ff;
   assign rsp_done_res = done_ff;

endmodule

### rtl/circle_rasterizer.sv
`timescale 1ns / 1ps
// Top level of the midpoint circle rasterizer.
// Depends on crast_pkg, crast_front, crast_queue and crast_back.

// A start request (req_type 0) loads center and radius and yields the eight
// mirrored points of offset (0, r); each step request (req_type 1) yields the
// next eight points, the eighth flagged last. A step after the octant is
// finished, or with no circle started, yields a single result with done_res
// and last set and zero coordinates. The front end updates the circle state
// in the cycle a request transfers and queues the step (queue depth
// QUEUE_DEPTH); the point sequencer emits one result per cycle, while
// rsp_stall is low, through an output register. Sustained throughput is set
// by that single result port; requests keep transferring back to back while
// the queue has room. A request's first result passes through the queue and
// then the output register.

module circle_rasterizer #(
   parameter int COORD_BITS  = crast_pkg::COORD_BITS_DEF,
   parameter int QUEUE_DEPTH = crast_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic        [COORD_BITS-2:0] req_radius,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [COORD_BITS:0]  rsp_point_x,
   output logic signed [COORD_BITS:0]  rsp_point_y,
   output logic                        rsp_last,
   output logic                        rsp_done_res
);

   localparam int CMD_BITS = 4 * COORD_BITS + 1;

   logic                queue_full;
   logic                cmd_push;
   logic [CMD_BITS-1:0] cmd_data;
   logic                head_valid;
   logic [CMD_BITS-1:0] head_data;
   logic                head_pop;

   crast_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .queue_full   (queue_full),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_data)
   );

   crast_queue #(
      .WIDTH (CMD_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_data),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   crast_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_data    (head_data),
      .head_pop     (head_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_point_x  (rsp_point_x),
      .rsp_point_y  (rsp_point_y),
      .rsp_last     (rsp_last),
      .rsp_done_res (rsp_done_res)
   );

   // A done result is always the only, hence last, result of its request
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> rsp_last)
      else $error("done result without last");

   // Done results carry zero coordinates
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_point_x == '0 && rsp_point_y == '0))
      else $error("done result with nonzero point");

   // Nothing is presented in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

### tb/circle_rasterizer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for circle_rasterizer: directed and random requests,
// predicted pixel stream compared in order. Depends on crast_pkg and the RTL top.

module circle_rasterizer_tb;

   localparam int CB        = crast_pkg::COORD_BITS_DEF;
   localparam int CALM_TAIL = 40;   // last pending requests go without idling
   localparam int RAND_REQS = 180;

   typedef struct {
      logic                  kind;
      logic signed [CB-1:0]  cx;
      logic signed [CB-1:0]  cy;
      logic        [CB-2:0]  rad;
      bit                    drain;  // hold off until every pixel is back
   } circle_req_type;

   typedef struct {
      logic signed [CB:0] px;
      logic signed [CB:0] py;
      logic               last;
      logic               done;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_type = crast_pkg::REQ_START;
   logic signed [CB-1:0]  req_center_x = '0;
   logic signed [CB-1:0]  req_center_y = '0;
   logic        [CB-2:0]  req_radius = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [CB:0]    rsp_point_x;
   logic signed [CB:0]    rsp_point_y;
   logic                  rsp_last;
   logic                  rsp_done_res;

   circle_rasterizer #(.COORD_BITS(CB)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_point_x  (rsp_point_x),
      .rsp_point_y  (rsp_point_y),
      .rsp_last     (rsp_last),
      .rsp_done_res (rsp_done_res)
   );

   circle_req_type req_pending[$];
   pixel_type      pixels_due[$];
   int             fail_count = 0;

   // Predictor state of the circle walker
   logic signed [CB-1:0] cen_x = '0;
   logic signed [CB-1:0] cen_y = '0;
   int                   ofs_x = 0;
   int                   ofs_y = 0;
   crast_pkg::dec_type   dvar = '0;
   bit                   drawing = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic void push_pixel(int px, int py, logic lst, logic dn);
      pixel_type p;
      p.px   = (CB+1)'(px);
      p.py   = (CB+1)'(py);
      p.last = lst;
      p.done = dn;
      pixels_due.push_back(p);
   endfunction

   // Eight mirrored pixels of the current offset, then one midpoint step
   function automatic void draw_octants();
      int cx;
      int cy;
      cx = cen_x;
      cy = cen_y;
      push_pixel(cx + ofs_x, cy + ofs_y, 1'b0, 1'b0);
      push_pixel(cx - ofs_x, cy + ofs_y, 1'b0, 1'b0);
      push_pixel(cx + ofs_x, cy - ofs_y, 1'b0, 1'b0);
      push_pixel(cx - ofs_x, cy - ofs_y, 1'b0, 1'b0);
      push_pixel(cx + ofs_y, cy + ofs_x, 1'b0, 1'b0);
      push_pixel(cx - ofs_y, cy + ofs_x, 1'b0, 1'b0);
      push_pixel(cx + ofs_y, cy - ofs_x, 1'b0, 1'b0);
      push_pixel(cx - ofs_y, cy - ofs_x, 1'b1, 1'b0);
      if (dvar < 0) begin
         dvar = dvar + crast_pkg::dec_type'(ofs_x << crast_pkg::DEC_SHIFT)
              + crast_pkg::INC_NEG;
      end else begin
         dvar = dvar + crast_pkg::dec_type'((ofs_x - ofs_y) << crast_pkg::DEC_SHIFT)
              + crast_pkg::INC_POS;
         ofs_y = ofs_y - 1;
      end
      ofs_x = ofs_x + 1;
   endfunction

   // Expected pixels for one transferred request
   function automatic void rasterize_req(circle_req_type r);
      if (r.kind == crast_pkg::REQ_START) begin
         cen_x   = r.cx;
         cen_y   = r.cy;
         ofs_x   = 0;
         ofs_y   = r.rad;
         dvar    = crast_pkg::DEC_INIT - crast_pkg::dec_type'(2 * int'(r.rad));
         drawing = 1'b1;
         draw_octants();
      end else if (!drawing || ofs_x > ofs_y) begin
         drawing = 1'b0;
         push_pixel(0, 0, 1'b1, 1'b1);
      end else begin
         draw_octants();
      end
   endfunction

   function automatic bit tail_calm();
      return req_pending.size() < CALM_TAIL;
   endfunction

   // Request driver
   circle_req_type cur_req;
   int             req_gap = 0;
   bit             req_fire;

   always @(posedge clock) begin
      req_fire = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_fire) begin
            rasterize_req(cur_req);
         end
         if (!req_valid || req_fire) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_valid <= 1'b0;
            end else if (req_pending.size() == 0) begin
               req_valid <= 1'b0;
            end else if (req_pending[0].drain && pixels_due.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               cur_req = req_pending.pop_front();
               req_type     <= cur_req.kind;
               req_center_x <= cur_req.cx;
               req_center_y <= cur_req.cy;
               req_radius   <= cur_req.rad;
               req_valid    <= 1'b1;
               if (!tail_calm() && $urandom_range(0, 5) == 0)
                  req_gap = $urandom_range(1, 6);
            end
         end
      end
   end

   // Pixel monitor and result-side stall
   int        stall_left = 0;
   pixel_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pixels_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t unexpected pixel x=%0d y=%0d last=%0b done=%0b", $realtime,
                           rsp_point_x, rsp_point_y, rsp_last, rsp_done_res);
            end else begin
               want = pixels_due.pop_front();
               if (rsp_point_x !== want.px || rsp_point_y !== want.py ||
                   rsp_last !== want.last || rsp_done_res !== want.done) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t pixel mismatch: want x=%0d y=%0d last=%0b done=%0b,",
                               " got x=%0d y=%0d last=%0b done=%0b"},
                              $realtime, want.px, want.py, want.last, want.done,
                              rsp_point_x, rsp_point_y, rsp_last, rsp_done_res);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!tail_calm() && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void add_req(logic kind, int cx, int cy, int rad, bit drain = 1'b0);
      circle_req_type r;
      r.kind  = kind;
      r.cx    = CB'(cx);
      r.cy    = CB'(cy);
      r.rad   = (CB-1)'(rad);
      r.drain = drain;
      req_pending.push_back(r);
   endfunction

   // Step with random, ignored operand fields
   function automatic void add_step();
      add_req(crast_pkg::REQ_STEP, $urandom_range(0, 2047), $urandom_range(0, 2047),
              $urandom_range(0, 1023));
   endfunction

   function automatic int add_circle(int cx, int cy, int rad, int steps, bit drain = 1'b0);
      add_req(crast_pkg::REQ_START, cx, cy, rad, drain);
      for (int i = 0; i < steps; i++)
         add_step();
      return steps + 1;
   endfunction

   // Stimulus, end of run
   int rand_count;
   int rad;
   int steps;

   initial begin
      // directed: idle step, zero radius, extremes, restart mid-circle, drain
      add_step();
      void'(add_circle(0, 0, 0, 2));
      void'(add_circle(-1024, -1024, 1023, 3));
      void'(add_circle(1023, 1023, 1023, 2));
      void'(add_circle(1023, -1024, 1, 3, 1'b1));
      void'(add_circle(-1024, 1023, 5, 6));
      void'(add_circle(0, 0, 1023, 1));

      rand_count = 0;
      while (rand_count < RAND_REQS) begin
         if ($urandom_range(0, 9) < 7) begin
            rad = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0)
               steps = $urandom_range(0, 4);
            else
               steps = (rad * 3 / 4 + 3 > 30) ? 30 : rad * 3 / 4 + 3;
            rand_count += add_circle($urandom_range(0, 2047), $urandom_range(0, 2047),
                                     rad, steps, rand_count > 100 && rand_count < 110);
         end else begin
            if ($urandom_range(0, 1) == 0)
               add_step();
            else
               add_req(crast_pkg::REQ_START, $urandom_range(0, 2047),
                       $urandom_range(0, 2047), $urandom_range(0, 1023));
            rand_count++;
         end
      end

      @(negedge reset);
      while (req_pending.size() != 0 || req_valid || pixels_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("circle_rasterizer_tb: clean");
      else
         $display("circle_rasterizer_tb: errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("circle_rasterizer_tb: errors");
      $finish;
   end

endmodule

### sim.f
rtl/crast_pkg.sv
rtl/crast_front.sv
rtl/crast_queue.sv
rtl/crast_back.sv
rtl/circle_rasterizer.sv
tb/circle_rasterizer_tb.sv
